// ===== hw/rtl/realtime_task_picker_assert.svh =====
// Assertion macros for the task picker.
`ifndef REALTIME_TASK_PICKER_ASSERT_SVH
`define REALTIME_TASK_PICKER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that cons holds in the same cycle whenever ante holds.
`define RTP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("realtime_task_picker: assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define RTP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("realtime_task_picker: assertion failed");

`else

`define RTP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RTP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/rtp_pkg.sv =====
package rtp_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;

   localparam int POLICY_W     = 2;
   localparam int TASK_COUNT_W = 5;
   localparam int SLOT_W       = 4;
   localparam int IDENT_W      = 16;
   localparam int TIME_W       = 32;
   localparam int ADDR_W       = 3;
   localparam int DATA_W       = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PICK  = 1'b1;

   localparam logic [POLICY_W-1:0] POL_EDF  = 2'd0;
   localparam logic [POLICY_W-1:0] POL_LSF  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_RMS  = 2'd2;
   localparam logic [POLICY_W-1:0] POL_NONE = 2'd3;

   // Register select is the word address bit of paddr.
   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_COUNT  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } rtp_state_type;

   // One table slot. prev and dmr are worked out when the slot is written.
   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [TIME_W-1:0]  period;
      logic [TIME_W-1:0]  deadline;
      logic [TIME_W-1:0]  prev;
      logic [TIME_W-1:0]  start;
      logic [TIME_W-1:0]  finish;
      logic [TIME_W-1:0]  dmr;
   } rtp_entry_type;

endpackage

// ===== hw/rtl/realtime_task_picker.sv =====
// A write request leaves the block idle, so it is ready again in the next cycle.
// A pick request scans n = min(task_count, MAX_TASKS) slots, none when the policy is
// unimplemented, through one table read port at one slot a cycle and a three-stage
// compare pipe; the response is registered once the pipe has drained, and the next
// request is taken in the cycle after the response is loaded.
// Synchronous active-high reset clears the control state and both registers; table
// slots hold unknown contents until written.
`include "realtime_task_picker_assert.svh"

module realtime_task_picker #(
   parameter int MAX_TASKS = rtp_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [rtp_pkg::SLOT_W-1:0]          req_slot,
   input  logic [rtp_pkg::IDENT_W-1:0]         req_task_ident,
   input  logic [rtp_pkg::TIME_W-1:0]          req_period_us,
   input  logic [rtp_pkg::TIME_W-1:0]          req_deadline_us,
   input  logic [rtp_pkg::TIME_W-1:0]          req_last_start_us,
   input  logic [rtp_pkg::TIME_W-1:0]          req_last_done_us,
   input  logic [rtp_pkg::TIME_W-1:0]          req_run_time_us,
   input  logic [rtp_pkg::TIME_W-1:0]          req_now_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [rtp_pkg::IDENT_W-1:0]         rsp_chosen_ident,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rtp_pkg::ADDR_W-1:0]          paddr,
   input  logic [rtp_pkg::DATA_W-1:0]          pwdata,
   output logic [rtp_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);
   import rtp_pkg::*;

   localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CntW = $clog2(MAX_TASKS + 1);
   localparam int ExtW = (CntW > TASK_COUNT_W) ? CntW : TASK_COUNT_W;

   rtp_state_type state_ff, state_in;

   logic [POLICY_W-1:0]     policy_ff, policy_in;
   logic [TASK_COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [CntW-1:0]         limit_ff, limit_in;
   logic [CntW-1:0]         issue_ff, issue_in;

   rtp_entry_type           entry_mem_ff [MAX_TASKS];
   rtp_entry_type           rd_entry_ff;
   rtp_entry_type           wr_entry;

   logic                    s1_vld_ff, s1_vld_in;
   logic                    s2_vld_ff, s2_vld_in;
   logic                    s2_ready_ff, s2_ready_in;
   logic [TIME_W-1:0]       s2_key_ff, s2_key_in;
   logic [IDENT_W-1:0]      s2_ident_ff, s2_ident_in;

   logic                    have_ff, have_in;
   logic [TIME_W-1:0]       best_key_ff, best_key_in;
   logic [IDENT_W-1:0]      best_ident_ff, best_ident_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [IDENT_W-1:0]      rsp_ident_ff, rsp_ident_in;

   logic                    req_accept;
   logic                    pick_accept;
   logic                    write_accept;
   logic                    csr_write;
   logic                    issue_en;
   logic                    scan_done;
   logic                    out_load;
   logic [ExtW-1:0]         slot_ext;
   logic [ExtW-1:0]         count_ext;
   logic [ExtW-1:0]         max_ext;
   logic [ExtW-1:0]         lim_ext;
   logic [TIME_W-1:0]       since;

   assign req_accept   = req_valid & req_ready;
   assign pick_accept  = req_accept && (req_cmd == CMD_PICK);
   assign slot_ext     = ExtW'(req_slot);
   assign max_ext      = ExtW'(MAX_TASKS);
   assign write_accept = req_accept && (req_cmd == CMD_WRITE) && (slot_ext < max_ext);

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      unique case (paddr[ADDR_W-1])
         REG_POLICY: prdata = DATA_W'(policy_ff);
         REG_COUNT:  prdata = DATA_W'(count_ff);
      endcase
   end

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_write) begin
         unique case (paddr[ADDR_W-1])
            REG_POLICY: policy_in = pwdata[POLICY_W-1:0];
            REG_COUNT:  count_in  = pwdata[TASK_COUNT_W-1:0];
         endcase
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pick_accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_ready = 1'b0;
      issue_en  = 1'b0;
      scan_done = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            issue_en  = (issue_ff < limit_ff);
            scan_done = (issue_ff == limit_ff) && !s1_vld_ff && !s2_vld_ff;
         end
         ST_FINISH: begin
            out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Scan limit and pick setup.
   assign count_ext = ExtW'(count_ff);
   assign lim_ext   = (count_ext > max_ext) ? max_ext : count_ext;

   always_comb begin
      now_in   = now_ff;
      limit_in = limit_ff;
      issue_in = issue_ff;
      if (pick_accept) begin
         now_in   = req_now_us;
         limit_in = (policy_ff == POL_NONE) ? '0 : CntW'(lim_ext);
         issue_in = '0;
      end else if (issue_en) begin
         issue_in = issue_ff + CntW'(1);
      end
   end

   // Table memory: one write port, one registered read port.
   always_comb begin
      wr_entry.ident    = req_task_ident;
      wr_entry.period   = req_period_us;
      wr_entry.deadline = req_deadline_us;
      wr_entry.prev     = req_deadline_us - req_period_us;
      wr_entry.start    = req_last_start_us;
      wr_entry.finish   = req_last_done_us;
      wr_entry.dmr      = req_deadline_us - req_run_time_us;
   end

   always_ff @(posedge clock) begin
      if (write_accept) begin
         entry_mem_ff[slot_ext[IdxW-1:0]] <= wr_entry;
      end
      if (issue_en) begin
         rd_entry_ff <= entry_mem_ff[issue_ff[IdxW-1:0]];
      end
   end

   // Stage two: readiness test and policy key of the slot just read.
   assign since = (policy_ff == POL_LSF) ? rd_entry_ff.finish : rd_entry_ff.start;

   always_comb begin
      s1_vld_in   = issue_en;
      s2_vld_in   = s1_vld_ff;
      s2_ready_in = (rd_entry_ff.prev >= since) && (now_ff > rd_entry_ff.prev);
      s2_ident_in = rd_entry_ff.ident;
      case (policy_ff)
         POL_EDF: s2_key_in = rd_entry_ff.deadline;
         POL_LSF: s2_key_in = rd_entry_ff.dmr - now_ff;
         default: s2_key_in = rd_entry_ff.period;
      endcase
   end

   // Stage three: a later slot replaces the candidate only on a strictly smaller key.
   always_comb begin
      have_in       = have_ff;
      best_key_in   = best_key_ff;
      best_ident_in = best_ident_ff;
      if (pick_accept) begin
         have_in = 1'b0;
      end else if (s2_vld_ff && s2_ready_ff && (!have_ff || (s2_key_ff < best_key_ff))) begin
         have_in       = 1'b1;
         best_key_in   = s2_key_ff;
         best_ident_in = s2_ident_ff;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = have_ff;
      rsp_ident_in = have_ff ? best_ident_ff : '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_EDF;
         count_ff     <= '0;
         limit_ff     <= '0;
         issue_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         issue_ff     <= issue_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      s2_ready_ff   <= s2_ready_in;
      s2_key_ff     <= s2_key_in;
      s2_ident_ff   <= s2_ident_in;
      best_key_ff   <= best_key_in;
      best_ident_ff <= best_ident_in;
      if (out_load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_ident_ff <= rsp_ident_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_chosen_ident = rsp_ident_ff;

   `RTP_ASSERT_IMPL(a_issue_bound, clock, reset, state_ff == ST_SCAN, issue_ff <= limit_ff)
   `RTP_ASSERT_IMPL(a_finish_drained, clock, reset, state_ff == ST_FINISH, !s1_vld_ff && !s2_vld_ff)
   `RTP_ASSERT_IMPL(a_none_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_ident_ff == '0)
   `RTP_ASSERT_NEXT(a_load_shows, clock, reset, out_load, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// ===== tb/sv/realtime_task_picker_tb.sv =====
`timescale 1ns / 100ps

module realtime_task_picker_tb;
   import rtp_pkg::*;

   localparam int     TABLE_DEPTH   = MAX_TASKS_DEFAULT;
   localparam int     ITEM_TARGET   = 1950;
   localparam int     SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     IDLE_PERCENT  = 18;
   localparam int     REPORT_LIMIT  = 10;
   localparam longint CYCLE_LIMIT   = 1000000;

   typedef struct {
      logic               cmd;
      logic [SLOT_W-1:0]  slot;
      logic [IDENT_W-1:0] ident;
      logic [TIME_W-1:0]  period;
      logic [TIME_W-1:0]  deadline;
      logic [TIME_W-1:0]  start;
      logic [TIME_W-1:0]  finish;
      logic [TIME_W-1:0]  run_time;
      logic [TIME_W-1:0]  now;
   } task_req_type;

   typedef struct {
      logic               found;
      logic [IDENT_W-1:0] ident;
   } pick_result_type;

   // Mirror of the task table and registers, plus the picks still owed by the block.
   class pick_board_type;
      logic [IDENT_W-1:0]      ident_tab    [TABLE_DEPTH];
      logic [TIME_W-1:0]       period_tab   [TABLE_DEPTH];
      logic [TIME_W-1:0]       deadline_tab [TABLE_DEPTH];
      logic [TIME_W-1:0]       start_tab    [TABLE_DEPTH];
      logic [TIME_W-1:0]       finish_tab   [TABLE_DEPTH];
      logic [TIME_W-1:0]       run_tab      [TABLE_DEPTH];
      logic [POLICY_W-1:0]     policy;
      logic [TASK_COUNT_W-1:0] count;
      pick_result_type         expected_picks[$];
      int unsigned             error_count;
      int unsigned             reported;

      function new();
         policy      = POL_EDF;
         count       = '0;
         error_count = 0;
         reported    = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            ident_tab[i]    = '0;
            period_tab[i]   = '0;
            deadline_tab[i] = '0;
            start_tab[i]    = '0;
            finish_tab[i]   = '0;
            run_tab[i]      = '0;
         end
      endfunction

      function void flag(string msg);
         error_count++;
         if (reported < REPORT_LIMIT) begin
            reported++;
            $display("[%0t] ERROR: %s", $realtime, msg);
         end
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction

      function void write_register(logic sel, logic [DATA_W-1:0] value);
         if (sel == REG_POLICY) begin
            policy = value[POLICY_W-1:0];
         end else begin
            count = value[TASK_COUNT_W-1:0];
         end
      endfunction

      // A task is a candidate when its previous deadline is not older than its
      // last start (last finish under least slack) and has already passed. Only a
      // strictly smaller key replaces the held candidate, so the lowest slot wins a tie.
      function pick_result_type choose_task(logic [TIME_W-1:0] now);
         pick_result_type    choice;
         logic [TIME_W-1:0]  best_key;
         logic [TIME_W-1:0]  prev;
         logic [TIME_W-1:0]  since;
         logic [TIME_W-1:0]  key;
         logic               have;
         int                 scan;
         choice.found = 1'b0;
         choice.ident = '0;
         have         = 1'b0;
         best_key     = '0;
         if (policy == POL_NONE) begin
            return choice;
         end
         scan = (int'(count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
         for (int i = 0; i < scan; i++) begin
            prev  = deadline_tab[i] - period_tab[i];
            since = (policy == POL_LSF) ? finish_tab[i] : start_tab[i];
            if (prev < since || !(now > prev)) begin
               continue;
            end
            case (policy)
               POL_EDF: key = deadline_tab[i];
               POL_LSF: key = deadline_tab[i] - now - run_tab[i];
               default: key = period_tab[i];
            endcase
            if (!have || key < best_key) begin
               have         = 1'b1;
               best_key     = key;
               choice.ident = ident_tab[i];
            end
         end
         choice.found = have;
         return choice;
      endfunction

      function void note_request(task_req_type r);
         if (r.cmd == CMD_PICK) begin
            expected_picks.push_back(choose_task(r.now));
         end else if (int'(r.slot) < TABLE_DEPTH) begin
            ident_tab[r.slot]    = r.ident;
            period_tab[r.slot]   = r.period;
            deadline_tab[r.slot] = r.deadline;
            start_tab[r.slot]    = r.start;
            finish_tab[r.slot]   = r.finish;
            run_tab[r.slot]      = r.run_time;
         end
      endfunction

      function void check_response(logic found, logic [IDENT_W-1:0] ident);
         pick_result_type want;
         if (expected_picks.size() == 0) begin
            flag($sformatf("unexpected pick result: found=%0b ident=%h", found, ident));
            return;
         end
         want = expected_picks.pop_front();
         if (found !== want.found || ident !== want.ident) begin
            flag($sformatf("pick mismatch: expected found=%0b ident=%h, got found=%0b ident=%h",
                           want.found, want.ident, found, ident));
         end
      endfunction

      function void close_out();
         if (expected_picks.size() != 0) begin
            flag($sformatf("%0d pick results never arrived", expected_picks.size()));
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_cmd;
   logic [SLOT_W-1:0]  req_slot;
   logic [IDENT_W-1:0] req_task_ident;
   logic [TIME_W-1:0]  req_period_us;
   logic [TIME_W-1:0]  req_deadline_us;
   logic [TIME_W-1:0]  req_last_start_us;
   logic [TIME_W-1:0]  req_last_done_us;
   logic [TIME_W-1:0]  req_run_time_us;
   logic [TIME_W-1:0]  req_now_us;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_found;
   logic [IDENT_W-1:0] rsp_chosen_ident;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   pick_board_type board = new();
   int unsigned    sent = 0;
   longint         cycle_count = 0;
   logic           steady = 1'b0;
   logic           hold_responses = 1'b0;
   int             hold_count;

   realtime_task_picker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_task_ident    (req_task_ident),
      .req_period_us     (req_period_us),
      .req_deadline_us   (req_deadline_us),
      .req_last_start_us (req_last_start_us),
      .req_last_done_us  (req_last_done_us),
      .req_run_time_us   (req_run_time_us),
      .req_now_us        (req_now_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_chosen_ident  (rsp_chosen_ident),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin : observe
      task_req_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_found, rsp_chosen_ident);
         end
         if (req_valid && req_ready) begin
            seen.cmd      = req_cmd;
            seen.slot     = req_slot;
            seen.ident    = req_task_ident;
            seen.period   = req_period_us;
            seen.deadline = req_deadline_us;
            seen.start    = req_last_start_us;
            seen.finish   = req_last_done_us;
            seen.run_time = req_run_time_us;
            seen.now      = req_now_us;
            board.note_request(seen);
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_responses) begin
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(posedge clock);
            end
            hold_responses = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic send_request(input task_req_type r);
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= r.cmd;
      req_slot          <= r.slot;
      req_task_ident    <= r.ident;
      req_period_us     <= r.period;
      req_deadline_us   <= r.deadline;
      req_last_start_us <= r.start;
      req_last_done_us  <= r.finish;
      req_run_time_us   <= r.run_time;
      req_now_us        <= r.now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_slot(input logic [SLOT_W-1:0] slot, input logic [IDENT_W-1:0] ident,
                             input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] deadline,
                             input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] finish,
                             input logic [TIME_W-1:0] run_time);
      task_req_type r;
      r.cmd      = CMD_WRITE;
      r.slot     = slot;
      r.ident    = ident;
      r.period   = period;
      r.deadline = deadline;
      r.start    = start;
      r.finish   = finish;
      r.run_time = run_time;
      r.now      = TIME_W'($urandom);
      send_request(r);
   endtask

   task automatic pick_at(input logic [TIME_W-1:0] now);
      task_req_type r;
      r.cmd      = CMD_PICK;
      r.slot     = SLOT_W'($urandom);
      r.ident    = IDENT_W'($urandom);
      r.period   = TIME_W'($urandom);
      r.deadline = TIME_W'($urandom);
      r.start    = TIME_W'($urandom);
      r.finish   = TIME_W'($urandom);
      r.run_time = TIME_W'($urandom);
      r.now      = now;
      send_request(r);
   endtask

   // One APB write that leaves psel high; set_regs releases the bus after its second write.
   task automatic csr_write(input logic sel, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.write_register(sel, value);
   endtask

   task automatic set_regs(input logic [POLICY_W-1:0] pol, input logic [TASK_COUNT_W-1:0] cnt);
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      // A write request can still be in flight when the last pick result is out.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_POLICY, DATA_W'(pol));
      csr_write(REG_COUNT, DATA_W'(cnt));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [TIME_W-1:0] since_near(input logic [TIME_W-1:0] prev);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return prev - TIME_W'($urandom_range(0, 200));
      end else if (roll < 85) begin
         return prev + TIME_W'($urandom_range(1, 50));
      end
      return prev;
   endfunction

   // Most requests are built around one epoch so that tasks are actually ready
   // and keys collide; the rest are fully random noise.
   function automatic task_req_type make_request(input logic [TIME_W-1:0] epoch);
      task_req_type      r;
      logic [TIME_W-1:0] prev;
      int unsigned       roll;
      r.cmd      = 1'($urandom);
      r.slot     = SLOT_W'($urandom);
      r.ident    = IDENT_W'($urandom);
      r.period   = TIME_W'($urandom);
      r.deadline = TIME_W'($urandom);
      r.start    = TIME_W'($urandom);
      r.finish   = TIME_W'($urandom);
      r.run_time = TIME_W'($urandom);
      r.now      = TIME_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         return r;
      end
      r.cmd = (roll < 57) ? CMD_WRITE : CMD_PICK;
      case ($urandom_range(0, 3))
         0, 1: r.period = TIME_W'($urandom_range(1, 8) * 64);
         2:    r.period = TIME_W'($urandom_range(0, 4000));
         default: r.period = TIME_W'($urandom);
      endcase
      r.deadline = epoch + TIME_W'($urandom_range(0, 8) * 64);
      prev       = r.deadline - r.period;
      r.start    = since_near(prev);
      r.finish   = since_near(prev);
      if ($urandom_range(0, 1) == 0) begin
         r.run_time = TIME_W'($urandom_range(0, 600));
      end
      r.now = epoch - TIME_W'(512) + TIME_W'($urandom_range(0, 1024));
      return r;
   endfunction

   initial begin : stimulus
      logic [TIME_W-1:0]       epoch;
      logic [TIME_W-1:0]       value;
      logic [POLICY_W-1:0]     pol;
      logic [TASK_COUNT_W-1:0] cnt;
      int unsigned             roll;
      int                      burst;
      int                      phase;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= CMD_WRITE;
      req_slot          <= '0;
      req_task_ident    <= '0;
      req_period_us     <= '0;
      req_deadline_us   <= '0;
      req_last_start_us <= '0;
      req_last_done_us  <= '0;
      req_run_time_us   <= '0;
      req_now_us        <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty scan straight out of reset, then fill the whole table.
      pick_at('0);
      write_slot(0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
      // Reference time equal to the previous deadline: not ready.
      write_slot(1, 16'h0000, 32'd100, 32'd1100, 32'd0, 32'd0, 32'd5);
      // Started exactly at the previous deadline, finished just after it.
      write_slot(2, 16'd2, 32'd50, 32'd900, 32'd850, 32'd851, 32'hFFFF_FFFF);
      write_slot(3, 16'd3, 32'd50, 32'd900, 32'd0, 32'd0, 32'd10);
      write_slot(4, 16'd4, 32'd0, 32'd500, 32'd500, 32'd400, 32'd0);
      for (int s = 5; s < TABLE_DEPTH; s++) begin
         value = TIME_W'($urandom);
         write_slot(SLOT_W'(s), IDENT_W'(s), value, value, '1, '1, TIME_W'($urandom));
      end
      set_regs(POL_EDF, TASK_COUNT_W'(TABLE_DEPTH));
      pick_at(32'd1000);
      pick_at(32'hFFFF_FFFF);
      set_regs(POL_LSF, TASK_COUNT_W'(TABLE_DEPTH));
      pick_at(32'd1000);
      set_regs(POL_RMS, TASK_COUNT_W'(TABLE_DEPTH));
      pick_at(32'd1000);
      // Slots 2 and 3 share the shortest period here.
      set_regs(POL_RMS, TASK_COUNT_W'(4));
      pick_at(32'd1000);
      set_regs(POL_NONE, TASK_COUNT_W'(TABLE_DEPTH));
      pick_at(32'd1000);

      phase = 0;
      while (sent < ITEM_TARGET) begin
         steady = (phase >= 8 && phase < 12);
         roll = $urandom_range(0, 9);
         if (roll < 3) begin
            pol = POL_EDF;
         end else if (roll < 6) begin
            pol = POL_LSF;
         end else if (roll < 9) begin
            pol = POL_RMS;
         end else begin
            pol = POL_NONE;
         end
         roll = $urandom_range(0, 9);
         if (roll < 3) begin
            cnt = TASK_COUNT_W'(TABLE_DEPTH);
         end else if (roll == 3) begin
            cnt = '0;
         end else begin
            cnt = TASK_COUNT_W'($urandom_range(1, TABLE_DEPTH - 1));
         end
         set_regs(pol, cnt);
         case ($urandom_range(0, 5))
            0: epoch = TIME_W'($urandom_range(0, 1500));
            1: epoch = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 1500));
            default: epoch = TIME_W'($urandom);
         endcase
         burst = $urandom_range(30, 90);
         for (int k = 0; k < burst; k++) begin
            if (phase == 3 && k == burst / 2) begin
               hold_responses = 1'b1;
            end
            if (phase == 6 && k == burst / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (board.pending() != 0);
            end
            send_request(make_request(epoch));
         end
         phase++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.close_out();
      if (board.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rtp_pkg.sv
hw/rtl/realtime_task_picker.sv
tb/sv/realtime_task_picker_tb.sv
